>>> hw/rtl/lcbm_pkg.sv
`timescale 1ns / 1ps

package lcbm_pkg;

	localparam int PRG_BANK_BITS_DEF = 4;
	localparam int CHR_BANK_BITS_DEF = 5;

	// widest bank select that the parameters allow
	localparam int BANK_MAX_BITS = 8;
	// PPU addresses below 2000 fit in 13 bits
	localparam int DVD_W = 13;
	localparam int DVS_W = 14;
	localparam int ADDR_W = 18;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;

	typedef enum logic [1:0] {
		KIND_CPU_RD = 2'd0,
		KIND_CPU_WR = 2'd1,
		KIND_PPU_RD = 2'd2,
		KIND_PPU_WR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_OPEN    = 3'd1,
		TGT_PRG_ROM = 3'd2,
		TGT_PRG_RAM = 3'd3,
		TGT_CHR_ROM = 3'd4,
		TGT_CHR_RAM = 3'd5
	} target_t;

	typedef enum logic [1:0] {
		OP_DIRECT,
		OP_PRG_MOD,
		OP_CHR_MOD,
		OP_RAM_MOD
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_RAM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_RST  = 3'd4;

	localparam logic [3:0] REG_PRG       = 4'hA;
	localparam logic [3:0] REG_CHR_FIRST = 4'hB;
	localparam logic [3:0] REG_CHR_LAST  = 4'hE;

	localparam logic [1:0] CHR_T0_FD = 2'd0;
	localparam logic [1:0] CHR_T0_FE = 2'd1;
	localparam logic [1:0] CHR_T1_FD = 2'd2;
	localparam logic [1:0] CHR_T1_FE = 2'd3;

	localparam logic [15:0] TILE_FD_T0 = 16'h0FD8;
	localparam logic [15:0] TILE_FE_T0 = 16'h0FE8;
	localparam logic [15:0] TILE_FD_T1 = 16'h1FD8;
	localparam logic [15:0] TILE_FE_T1 = 16'h1FE8;
	localparam logic [15:0] CPU_REG_BASE = 16'hA000;
	localparam logic [2:0] PRG_RAM_PAGE = 3'b011;

	typedef struct packed {
		op_t                    op;
		target_t                target;
		logic [ADDR_W-1:0]      addr;
		logic [DVD_W-1:0]       dividend;
		logic [DVS_W-1:0]       divisor;
		logic                   mem_write;
		logic [7:0]             store_data;
		logic                   mirror;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> hw/rtl/lcbm_channels.sv
`timescale 1ns / 1ps

interface lcbm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, kind, address, write_data, input ready);
	modport sink (input valid, kind, address, write_data, output ready);
endinterface

interface lcbm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  target;
	logic [17:0] mem_address;
	logic        mem_write;
	logic [7:0]  store_data;
	logic        mirror_vertical;

	modport source (output valid, target, mem_address, mem_write, store_data,
		mirror_vertical, input ready);
	modport sink (input valid, target, mem_address, mem_write, store_data,
		mirror_vertical, output ready);
endinterface

>>> hw/rtl/lcbm_front.sv
`timescale 1ns / 1ps

module lcbm_front
	import lcbm_pkg::*;
#(
	parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
	parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lcbm_req_if.sink              req,
	input  qstat_t                qstat,
	output logic                  push,
	output job_t                  job
);

	logic [4:0]  prg_cnt_q;
	logic [5:0]  chr_cnt_q;
	logic        ram_present_q;
	logic [13:0] chr_ram_q;
	logic        mirror_rst_q;

	logic [PRG_BANK_BITS-1:0] prg_sel_q, prg_sel_d;
	logic [CHR_BANK_BITS-1:0] chr_sel_q [4];
	logic [CHR_BANK_BITS-1:0] chr_sel_d [4];
	logic                     latch0_q, latch0_d;
	logic                     latch1_q, latch1_d;
	logic                     mirror_q, mirror_d;

	logic [15:0]              a;
	logic [7:0]               d;
	logic                     cpu_wr;
	logic [4:0]               prg_cnt_eff;
	logic [4:0]               prg_last;
	logic [3:0]               reg_sel;
	logic [1:0]               chr_idx;
	logic [CHR_BANK_BITS-1:0] chr_bank;

	assign a = req.address;
	assign d = req.write_data;
	assign cpu_wr = (kind_t'(req.kind) == KIND_CPU_WR);
	assign prg_cnt_eff = (prg_cnt_q == 5'd0) ? 5'd1 : prg_cnt_q;
	assign prg_last = prg_cnt_eff - 5'd1;
	assign reg_sel = a[15:12];
	assign chr_idx = 2'(reg_sel - REG_CHR_FIRST);
	// bank chosen by the latch as it stood before this fetch
	assign chr_bank = a[12] ? chr_sel_q[latch1_q ? CHR_T1_FD : CHR_T1_FE]
		: chr_sel_q[latch0_q ? CHR_T0_FD : CHR_T0_FE];

	assign req.ready = !qstat.full;
	assign push = req.valid && !qstat.full;

	always_comb begin
		job = '0;
		job.op = OP_DIRECT;
		job.target = TGT_NONE;
		prg_sel_d = prg_sel_q;
		chr_sel_d = chr_sel_q;
		latch0_d = latch0_q;
		latch1_d = latch1_q;
		mirror_d = mirror_q;
		unique case (kind_t'(req.kind))
			KIND_CPU_RD, KIND_CPU_WR: begin
				if (a[15:13] == PRG_RAM_PAGE) begin
					if (ram_present_q) begin
						job.target = TGT_PRG_RAM;
						job.addr = ADDR_W'(a[12:0]);
						if (cpu_wr) begin
							job.mem_write = 1'b1;
							job.store_data = d;
						end
					end else begin
						job.target = cpu_wr ? TGT_NONE : TGT_OPEN;
					end
				end else if (!cpu_wr) begin
					if (a[15:14] == 2'b11) begin
						job.target = TGT_PRG_ROM;
						job.addr = {prg_last[3:0], a[13:0]};
					end else if (a[15]) begin
						job.target = TGT_PRG_ROM;
						job.op = OP_PRG_MOD;
						job.addr = ADDR_W'(a[13:0]);
						job.dividend = DVD_W'(prg_sel_q);
						job.divisor = DVS_W'(prg_cnt_eff);
					end
				end else if (a >= CPU_REG_BASE) begin
					priority if (reg_sel == REG_PRG) begin
						prg_sel_d = d[PRG_BANK_BITS-1:0];
					end else if (reg_sel <= REG_CHR_LAST) begin
						chr_sel_d[chr_idx] = d[CHR_BANK_BITS-1:0];
					end else begin
						mirror_d = d[0];
					end
				end
			end
			KIND_PPU_RD: begin
				if (a[15:13] == 3'b000) begin
					if (chr_cnt_q != 6'd0) begin
						job.target = TGT_CHR_ROM;
						job.op = OP_CHR_MOD;
						job.addr = ADDR_W'(a[11:0]);
						job.dividend = DVD_W'(chr_bank);
						job.divisor = DVS_W'(chr_cnt_q);
					end else if (chr_ram_q != 14'd0) begin
						job.target = TGT_CHR_RAM;
						job.op = OP_RAM_MOD;
						job.dividend = a[DVD_W-1:0];
						job.divisor = chr_ram_q;
					end
					if (a[15:3] == TILE_FD_T0[15:3]) latch0_d = 1'b1;
					else if (a[15:3] == TILE_FE_T0[15:3]) latch0_d = 1'b0;
					if (a[15:3] == TILE_FD_T1[15:3]) latch1_d = 1'b1;
					else if (a[15:3] == TILE_FE_T1[15:3]) latch1_d = 1'b0;
				end
			end
			KIND_PPU_WR: begin
				if (a[15:13] == 3'b000 && chr_ram_q != 14'd0) begin
					job.target = TGT_CHR_RAM;
					job.op = OP_RAM_MOD;
					job.dividend = a[DVD_W-1:0];
					job.divisor = chr_ram_q;
					job.mem_write = 1'b1;
					job.store_data = d;
				end
			end
			default: ;
		endcase
		job.mirror = mirror_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_cnt_q <= 5'd8;
			chr_cnt_q <= 6'd32;
			ram_present_q <= 1'b1;
			chr_ram_q <= 14'd0;
			mirror_rst_q <= 1'b0;
			prg_sel_q <= '0;
			for (int i = 0; i < 4; i++) chr_sel_q[i] <= '0;
			latch0_q <= 1'b0;
			latch1_q <= 1'b0;
			mirror_q <= 1'b0;
		end else begin
			if (push) begin
				prg_sel_q <= prg_sel_d;
				chr_sel_q <= chr_sel_d;
				latch0_q <= latch0_d;
				latch1_q <= latch1_d;
				mirror_q <= mirror_d;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PRG_COUNT:  prg_cnt_q <= cfg_data[4:0];
					CFG_CHR_COUNT:  chr_cnt_q <= cfg_data[5:0];
					CFG_PRG_RAM:    ram_present_q <= cfg_data[0];
					CFG_CHR_RAM:    chr_ram_q <= cfg_data;
					CFG_MIRROR_RST: begin
						mirror_rst_q <= cfg_data[0];
						mirror_q <= cfg_data[0];
					end
					default: ;
				endcase
			end
		end
	end

	// mirror_rst_q only shadows the value loaded into mirror_q
	logic unused_mirror_rst;
	assign unused_mirror_rst = mirror_rst_q;

endmodule

>>> hw/rtl/lcbm_queue.sv
`timescale 1ns / 1ps

module lcbm_queue
	import lcbm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   job_in,
	input  logic   pop,
	output job_t   job_out,
	output qstat_t qstat
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign qstat.full = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign job_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue pop while empty");

endmodule

>>> hw/rtl/lcbm_back.sv
`timescale 1ns / 1ps

module lcbm_back
	import lcbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  qstat_t    qstat,
	input  job_t      q_job,
	output logic      pop,
	lcbm_rsp_if.source rsp
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	job_t               job_q;
	logic [DVS_W-1:0]   rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic               out_valid_q;
	target_t            out_target_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_write_q;
	logic [7:0]         out_data_q;
	logic               out_mirror_q;

	logic               can_load;
	logic               finish;
	logic [DVS_W:0]     trial;
	logic [DVS_W:0]     trial_sub;
	logic [DVS_W-1:0]   rem_step;
	logic [ADDR_W-1:0]  addr_res;
	logic [DVD_W-1:0]   dvd_load;
	logic [CNT_W-1:0]   cnt_load;

	assign can_load = !out_valid_q || rsp.ready;
	assign finish = (state_q == ST_RUN) && (cnt_q == '0) && can_load;
	assign pop = !qstat.empty && ((state_q == ST_IDLE) || finish);

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign trial_sub = trial - {1'b0, job_q.divisor};
	assign rem_step = (trial >= {1'b0, job_q.divisor}) ? trial_sub[DVS_W-1:0]
		: trial[DVS_W-1:0];

	always_comb begin
		unique case (q_job.op)
			OP_DIRECT: begin
				dvd_load = q_job.dividend;
				cnt_load = '0;
			end
			OP_RAM_MOD: begin
				dvd_load = q_job.dividend;
				cnt_load = CNT_W'(DVD_W);
			end
			default: begin
				// bank numbers sit left aligned so only their bits are walked
				dvd_load = q_job.dividend << (DVD_W - BANK_MAX_BITS);
				cnt_load = CNT_W'(BANK_MAX_BITS);
			end
		endcase
	end

	always_comb begin
		unique case (job_q.op)
			OP_DIRECT:  addr_res = job_q.addr;
			OP_PRG_MOD: addr_res = {rem_q[3:0], job_q.addr[13:0]};
			OP_CHR_MOD: addr_res = {rem_q[5:0], job_q.addr[11:0]};
			default:    addr_res = ADDR_W'(rem_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			if (state_q == ST_RUN && cnt_q != '0) begin
				rem_q <= rem_step;
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				out_target_q <= job_q.target;
				out_addr_q <= addr_res;
				out_write_q <= job_q.mem_write;
				out_data_q <= job_q.store_data;
				out_mirror_q <= job_q.mirror;
				state_q <= ST_IDLE;
			end
			if (pop) begin
				job_q <= q_job;
				rem_q <= '0;
				dvd_q <= dvd_load;
				cnt_q <= cnt_load;
				state_q <= ST_RUN;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.target = out_target_q;
	assign rsp.mem_address = out_addr_q;
	assign rsp.mem_write = out_write_q;
	assign rsp.store_data = out_data_q;
	assign rsp.mirror_vertical = out_mirror_q;

	a_load_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RUN && cnt_q == '0))
		else $error("result loaded outside a finished job");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && job_q.op != OP_DIRECT) |-> (rem_q < job_q.divisor))
		else $error("remainder out of range");

endmodule

>>> hw/rtl/latched_chr_bank_mapper_unit.sv
`timescale 1ns / 1ps
// Path: an accepted request beat enters the queue, then the back-end job register,
// then the result register; a switched PRG or CHR-ROM bank or a CHR-RAM access
// first runs the bit-serial remainder unit. Throughput: one beat per cycle for direct
// mappings while rsp is ready; a bank or CHR-RAM access holds the back end until done.
// Reset: async active low; config returns to 8 PRG banks, 32 CHR banks, PRG RAM on,
// no CHR RAM, horizontal mirroring; bank selects and both latches clear to zero.

module latched_chr_bank_mapper_unit
	import lcbm_pkg::*;
#(
	parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
	parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lcbm_req_if.sink              req,
	lcbm_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	qstat_t qstat;
	logic   push;
	logic   pop;
	job_t   job_in;
	job_t   job_out;

	lcbm_front #(
		.PRG_BANK_BITS(PRG_BANK_BITS),
		.CHR_BANK_BITS(CHR_BANK_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.qstat     (qstat),
		.push      (push),
		.job       (job_in)
	);

	lcbm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.qstat   (qstat)
	);

	lcbm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.q_job  (job_out),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

>>> dv/tb_latched_chr_bank_mapper_unit.sv
`timescale 1ns / 1ps

module tb_latched_chr_bank_mapper_unit;
	import lcbm_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_PCT = 18;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [7:0]  data;
	} bus_access_t;

	typedef struct packed {
		target_t     target;
		logic [17:0] mem_address;
		logic        mem_write;
		logic [7:0]  store_data;
		logic        mirror;
	} map_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lcbm_req_if req_ch ();
	lcbm_rsp_if rsp_ch ();

	latched_chr_bank_mapper_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mapper copy: configuration
	logic [4:0]  prg_count;
	logic [5:0]  chr_count;
	logic        prg_ram_on;
	logic [13:0] chr_ram_len;
	logic        mirror_rst;
	// mapper copy: bank state
	logic [PRG_BANK_BITS_DEF-1:0] prg_sel;
	logic [CHR_BANK_BITS_DEF-1:0] chr_sel [4];
	logic        latch0_fd;
	logic        latch1_fd;
	logic        mirror_state;

	map_result_t pending_maps [$];
	int          errors = 0;
	int unsigned cycle_count = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	int          rx_hold_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("latched_chr_bank_mapper_unit test failed");
			$finish;
		end
	end

	function automatic bus_access_t acc_of(kind_t k, logic [15:0] a, logic [7:0] d);
		bus_access_t acc;
		acc.kind = k;
		acc.address = a;
		acc.data = d;
		return acc;
	endfunction

	// Computes the mapping of one access and advances the bank state.
	function automatic map_result_t map_access(bus_access_t acc);
		map_result_t r;
		int unsigned a, cnt, bank;
		logic wr;
		logic [3:0] reg_sel;
		a = acc.address;
		r.target = TGT_NONE;
		r.mem_address = '0;
		r.mem_write = 1'b0;
		r.store_data = '0;
		r.mirror = 1'b0;
		case (acc.kind)
		KIND_CPU_RD, KIND_CPU_WR: begin
			wr = (acc.kind == KIND_CPU_WR);
			cnt = (prg_count == 0) ? 1 : prg_count;
			if (acc.address[15:13] == PRG_RAM_PAGE) begin
				if (prg_ram_on) begin
					r.target = TGT_PRG_RAM;
					r.mem_address = 18'(a - 'h6000);
					r.mem_write = wr;
				end else begin
					r.target = wr ? TGT_NONE : TGT_OPEN;
				end
			end else if (!wr) begin
				if (a >= 'hC000) begin
					r.target = TGT_PRG_ROM;
					r.mem_address = 18'((cnt - 1) * 16384 + (a - 'hC000));
				end else if (a >= 'h8000) begin
					r.target = TGT_PRG_ROM;
					r.mem_address = 18'((prg_sel % cnt) * 16384 + (a - 'h8000));
				end
			end else if (acc.address >= CPU_REG_BASE) begin
				reg_sel = acc.address[15:12];
				if (reg_sel == REG_PRG)
					prg_sel = acc.data[PRG_BANK_BITS_DEF-1:0];
				else if (reg_sel >= REG_CHR_FIRST && reg_sel <= REG_CHR_LAST)
					chr_sel[2'(reg_sel - REG_CHR_FIRST)] = acc.data[CHR_BANK_BITS_DEF-1:0];
				else
					mirror_state = acc.data[0];
			end
		end
		KIND_PPU_RD: begin
			if (a <= 'h1FFF) begin
				if (!acc.address[12])
					bank = chr_sel[latch0_fd ? CHR_T0_FD : CHR_T0_FE];
				else
					bank = chr_sel[latch1_fd ? CHR_T1_FD : CHR_T1_FE];
				if (chr_count != 0) begin
					r.target = TGT_CHR_ROM;
					r.mem_address = 18'((bank % chr_count) * 4096 + (a & 'hFFF));
				end else if (chr_ram_len != 0) begin
					r.target = TGT_CHR_RAM;
					r.mem_address = 18'(a % chr_ram_len);
				end
				// latch moves after this fetch has used the old value
				if (a >= TILE_FD_T0 && a <= TILE_FD_T0 + 7)
					latch0_fd = 1'b1;
				else if (a >= TILE_FE_T0 && a <= TILE_FE_T0 + 7)
					latch0_fd = 1'b0;
				if (a >= TILE_FD_T1 && a <= TILE_FD_T1 + 7)
					latch1_fd = 1'b1;
				else if (a >= TILE_FE_T1 && a <= TILE_FE_T1 + 7)
					latch1_fd = 1'b0;
			end
		end
		default: begin
			if (a <= 'h1FFF && chr_ram_len != 0) begin
				r.target = TGT_CHR_RAM;
				r.mem_address = 18'(a % chr_ram_len);
				r.mem_write = 1'b1;
			end
		end
		endcase
		r.store_data = r.mem_write ? acc.data : 8'h00;
		r.mirror = mirror_state;
		return r;
	endfunction

	task automatic issue_access(bus_access_t acc);
		while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= acc.kind;
		req_ch.address <= acc.address;
		req_ch.write_data <= acc.data;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_maps.push_back(map_access(acc));
	endtask

	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		while (pending_maps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		CFG_PRG_COUNT:  prg_count = val[4:0];
		CFG_CHR_COUNT:  chr_count = val[5:0];
		CFG_PRG_RAM:    prg_ram_on = val[0];
		CFG_CHR_RAM:    chr_ram_len = val;
		CFG_MIRROR_RST: begin
			mirror_rst = val[0];
			mirror_state = val[0];
		end
		default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_cfg(int prg, int chr, int ram, int chr_ram, int mir);
		write_cfg(CFG_PRG_COUNT, 14'(prg));
		write_cfg(CFG_CHR_COUNT, 14'(chr));
		write_cfg(CFG_PRG_RAM, 14'(ram));
		write_cfg(CFG_CHR_RAM, 14'(chr_ram));
		write_cfg(CFG_MIRROR_RST, 14'(mir));
	endtask

	// Mostly plausible bus traffic: pattern fetches near latch tiles, register
	// writes, RAM and ROM traffic; the rest is noise over the whole space.
	function automatic bus_access_t rand_access();
		bus_access_t acc;
		int unsigned pick;
		logic [15:0] base;
		pick = $urandom_range(99);
		acc.data = 8'($urandom);
		acc.address = 16'($urandom);
		acc.kind = kind_t'($urandom_range(3));
		if (pick < 30) begin
			acc.kind = KIND_PPU_RD;
			if ($urandom_range(1) == 0) begin
				case ($urandom_range(3))
				0: base = TILE_FD_T0;
				1: base = TILE_FE_T0;
				2: base = TILE_FD_T1;
				default: base = TILE_FE_T1;
				endcase
				acc.address = 16'(base + $urandom_range(9) - 1);
			end else begin
				acc.address = 16'($urandom_range('h1FFF));
			end
		end else if (pick < 45) begin
			acc.kind = KIND_CPU_WR;
			acc.address = {4'($urandom_range(10, 15)), 12'($urandom)};
		end else if (pick < 53) begin
			acc.kind = KIND_PPU_WR;
			acc.address = 16'($urandom_range('h1FFF));
		end else if (pick < 58) begin
			acc.kind = KIND_CPU_WR;
			acc.address = 16'($urandom_range('h6000, 'h7FFF));
		end else if (pick < 83) begin
			acc.kind = KIND_CPU_RD;
		end
		return acc;
	endfunction

	task automatic run_random(int n);
		repeat (n) issue_access(rand_access());
		wait_for_drain();
	endtask

	task automatic test_directed_defaults();
		issue_access(acc_of(KIND_CPU_RD, 16'h0000, 8'h00));
		issue_access(acc_of(KIND_CPU_RD, 16'h5FFF, 8'hFF));
		issue_access(acc_of(KIND_CPU_WR, 16'h6000, 8'hAA));
		issue_access(acc_of(KIND_CPU_RD, 16'h7FFF, 8'h00));
		issue_access(acc_of(KIND_CPU_RD, 16'h8000, 8'h00));
		issue_access(acc_of(KIND_CPU_WR, 16'hA000, 8'hFF));
		issue_access(acc_of(KIND_CPU_RD, 16'hBFFF, 8'h00));
		issue_access(acc_of(KIND_CPU_RD, 16'hC000, 8'h00));
		issue_access(acc_of(KIND_CPU_RD, 16'hFFFF, 8'h00));
		issue_access(acc_of(KIND_CPU_WR, 16'hB000, 8'hFF));
		issue_access(acc_of(KIND_CPU_WR, 16'hC000, 8'h03));
		issue_access(acc_of(KIND_CPU_WR, 16'hD000, 8'h1E));
		issue_access(acc_of(KIND_CPU_WR, 16'hEFFF, 8'h05));
		// latch tile fetch uses the old latch, next fetch sees the new one
		issue_access(acc_of(KIND_PPU_RD, 16'h0FD8, 8'h00));
		issue_access(acc_of(KIND_PPU_RD, 16'h0000, 8'h00));
		issue_access(acc_of(KIND_PPU_RD, 16'h0FEF, 8'h00));
		issue_access(acc_of(KIND_PPU_RD, 16'h0FFF, 8'h00));
		issue_access(acc_of(KIND_PPU_RD, 16'h1FDF, 8'h00));
		issue_access(acc_of(KIND_PPU_RD, 16'h1FE8, 8'h00));
		issue_access(acc_of(KIND_PPU_RD, 16'h2000, 8'h00));
		issue_access(acc_of(KIND_PPU_WR, 16'h1FFF, 8'hFF));
		issue_access(acc_of(KIND_CPU_WR, 16'hF000, 8'h01));
		issue_access(acc_of(KIND_CPU_WR, 16'hFFFF, 8'hFE));
		issue_access(acc_of(KIND_CPU_WR, 16'h4020, 8'h55));
		issue_access(acc_of(KIND_PPU_RD, 16'hFFFF, 8'h00));
		wait_for_drain();
	endtask

	task automatic test_config_extremes();
		apply_cfg(16, 32, 1, 0, 0);
		run_random(140);
		apply_cfg(1, 0, 0, 8192, 1);
		run_random(140);
		// zero PRG count acts as one bank; no CHR memory at all
		apply_cfg(0, 0, 1, 0, 1);
		run_random(140);
		// field maxima: PRG offsets overflow 18 bits
		apply_cfg(31, 63, 0, 16383, 0);
		run_random(140);
		apply_cfg(1, 1, 1, 1, 1);
		run_random(140);
		apply_cfg(3, 5, 0, 3000, 0);
		run_random(140);
	endtask

	task automatic test_random_configs();
		repeat (3) begin
			apply_cfg($urandom_range(1, 16), $urandom_range(0, 32), $urandom_range(1),
				($urandom_range(1) == 0) ? 0 : $urandom_range(1, 8192), $urandom_range(1));
			run_random(120);
		end
	endtask

	task automatic test_no_idle_stretch();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		apply_cfg(8, 0, 1, 6000, 1);
		run_random(250);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_fill_stall();
		tx_idle_en = 1'b0;
		rx_hold_left = 400;
		run_random(80);
		tx_idle_en = 1'b1;
	endtask

	// result side: random ready, optional long hold, in-order compare
	initial begin
		map_result_t exp_r;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_maps.size() == 0) begin
					$error("result beat with no access pending");
					errors++;
				end else begin
					exp_r = pending_maps.pop_front();
					if (rsp_ch.target !== exp_r.target) begin
						$error("target: expected %0d, actual %0d", exp_r.target, rsp_ch.target);
						errors++;
					end
					if (rsp_ch.mem_address !== exp_r.mem_address) begin
						$error("mem_address: expected %0h, actual %0h", exp_r.mem_address,
							rsp_ch.mem_address);
						errors++;
					end
					if (rsp_ch.mem_write !== exp_r.mem_write) begin
						$error("mem_write: expected %0d, actual %0d", exp_r.mem_write,
							rsp_ch.mem_write);
						errors++;
					end
					if (rsp_ch.store_data !== exp_r.store_data) begin
						$error("store_data: expected %0h, actual %0h", exp_r.store_data,
							rsp_ch.store_data);
						errors++;
					end
					if (rsp_ch.mirror_vertical !== exp_r.mirror) begin
						$error("mirror_vertical: expected %0d, actual %0d", exp_r.mirror,
							rsp_ch.mirror_vertical);
						errors++;
					end
				end
			end
			if (rx_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold_left--;
			end else begin
				rsp_ch.ready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PRG_COUNT;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_CPU_RD;
		req_ch.address <= '0;
		req_ch.write_data <= '0;
		prg_count = 5'd8;
		chr_count = 6'd32;
		prg_ram_on = 1'b1;
		chr_ram_len = '0;
		mirror_rst = 1'b0;
		prg_sel = '0;
		foreach (chr_sel[i])
			chr_sel[i] = '0;
		latch0_fd = 1'b0;
		latch1_fd = 1'b0;
		mirror_state = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_config_extremes();
		test_random_configs();
		test_no_idle_stretch();
		test_fill_stall();
		wait_for_drain();

		if (errors == 0) begin
			$display("latched_chr_bank_mapper_unit test passed");
		end else begin
			$display("latched_chr_bank_mapper_unit test failed");
		end
		$finish;
	end

endmodule
